@@ design/axbbp_pkg.sv @@
// ----------------------------------------------------------------------------
// axbbp_pkg
// Shared types and constants for the bang-bang axis positioner.
// ----------------------------------------------------------------------------
`default_nettype none

package axbbp_pkg;

  localparam int unsigned CountsPerCm      = 3855;
  localparam int unsigned CmPerWrap        = 17;
  localparam int unsigned WrapHighThresh   = 61680;
  localparam int unsigned PosMax           = 8191;

  // count / CountsPerCm as (count * RecipMul) >> RecipShift, exact on 16 bits
  localparam int unsigned       RecipShift = 32;
  localparam longint unsigned   RecipMul   =
      ((64'd1 << RecipShift) + 64'(CountsPerCm) - 64'd1) / 64'(CountsPerCm);
  localparam int unsigned       RecipW     = 21;

  localparam int unsigned DutyW   = 10;
  localparam int unsigned DbandW  = 8;
  localparam int unsigned TargetW = 10;
  localparam int unsigned CountW  = 16;
  localparam int unsigned PosW    = 13;
  localparam int unsigned RevW    = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [DutyW-1:0]  UpDutyRst   = 10'd450;
  localparam logic [DutyW-1:0]  DownDutyRst = 10'd100;
  localparam logic [DutyW-1:0]  HoldDutyRst = 10'd200;
  localparam logic [DutyW-1:0]  HomeDutyRst = 10'd115;
  localparam logic [DbandW-1:0] DbandRst    = 8'd24;

  typedef enum logic [1:0] {
    OpBeginHome = 2'd0,
    OpHomeHit   = 2'd1,
    OpStartMove = 2'd2,
    OpSample    = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgUpDuty   = 3'd0,
    CfgDownDuty = 3'd1,
    CfgHoldDuty = 3'd2,
    CfgHomeDuty = 3'd3,
    CfgDband    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    op_e                op;
    logic [TargetW-1:0] target_q4;
    logic [CountW-1:0]  encoder_count;
  } item_t;

endpackage

`default_nettype wire

@@ design/axis_bang_bang_positioner.sv @@
// ----------------------------------------------------------------------------
// axis_bang_bang_positioner
// Bang-bang position control of one axis with encoder wrap tracking.
// ----------------------------------------------------------------------------
// Takes one item per clock while the result is not stalled: an item is
// captured in an input register, the position (count / 3855 by reciprocal
// multiply, plus revolutions * 17), the wrap tracking and the drive decision
// are computed combinationally from that register and land in the result
// register, together with the state update. A stalled result holds the input
// register, and a new item is still taken when the result leaves.
`default_nettype none

module axis_bang_bang_positioner (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [axbbp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [axbbp_pkg::DutyW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  axbbp_pkg::op_e               op_i,
  input  logic [axbbp_pkg::TargetW-1:0] target_q4_i,
  input  logic [axbbp_pkg::CountW-1:0] encoder_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [axbbp_pkg::DutyW-1:0]  duty_o,
  output logic                         toward_home_o,
  output logic                         enable_o,
  output logic [axbbp_pkg::PosW-1:0]   position_cm_o,
  output logic                         arrived_o
);
  import axbbp_pkg::*;

  localparam int unsigned ProdW  = CountW + RecipW;
  localparam int unsigned QuotW  = ProdW - RecipShift;
  localparam int unsigned DeltaW = PosW + 6;

  logic [DutyW-1:0]  up_duty_q, down_duty_q, hold_duty_q, home_duty_q;
  logic [DbandW-1:0] dband_q;

  logic [RevW-1:0]   rev_q, rev_d;
  logic              armed_q, armed_d;
  logic              last_pos_q, last_pos_d;
  logic [PosW-1:0]   pos_q, pos_d;

  item_t             item_q;
  logic              s1_valid_q;
  logic              s1_adv;
  logic              out_valid_q;

  logic [DutyW-1:0]  duty_d;
  logic              toward_d, enable_d, arrived_d;

  logic [ProdW-1:0]  prod;
  logic [QuotW-1:0]  quot;
  logic [31:0]       pos_wide;
  logic [PosW-1:0]   pos_calc;
  logic              hi, lo;
  logic signed [DeltaW-1:0] delta;
  logic [DeltaW-1:0] mag;
  logic              drive;

  assign s1_adv      = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_duty_q   <= UpDutyRst;
      down_duty_q <= DownDutyRst;
      hold_duty_q <= HoldDutyRst;
      home_duty_q <= HomeDutyRst;
      dband_q     <= DbandRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgUpDuty:   up_duty_q   <= cfg_data_i;
        CfgDownDuty: down_duty_q <= cfg_data_i;
        CfgHoldDuty: hold_duty_q <= cfg_data_i;
        CfgHomeDuty: home_duty_q <= cfg_data_i;
        CfgDband:    dband_q     <= cfg_data_i[DbandW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= '{op: op_i, target_q4: target_q4_i, encoder_count: encoder_count_i};
    end
  end

  assign prod     = ProdW'(item_q.encoder_count) * ProdW'(RecipW'(RecipMul));
  assign quot     = prod[ProdW-1:RecipShift];
  assign hi       = 32'(item_q.encoder_count) > 32'(WrapHighThresh);
  assign lo       = 32'(item_q.encoder_count) < 32'(CountsPerCm);

  always_comb begin
    rev_d      = rev_q;
    armed_d    = armed_q;
    if (item_q.op == OpSample) begin
      priority if (hi && last_pos_q && armed_q) begin
        armed_d = 1'b0;
      end else if (lo && last_pos_q && !armed_q) begin
        armed_d = 1'b1;
        rev_d   = rev_q + RevW'(1);
      end else if (lo && !last_pos_q) begin
        armed_d = 1'b0;
      end else if (hi && !last_pos_q && !armed_q) begin
        armed_d = 1'b1;
        rev_d   = rev_q - RevW'(1);
      end else begin
        armed_d = armed_q;
      end
    end
    if (item_q.op == OpHomeHit) begin
      rev_d = '0;
    end
  end

  assign pos_wide = 32'(quot) + 32'(rev_d) * 32'(CmPerWrap);
  assign pos_calc = (pos_wide > 32'(PosMax)) ? PosW'(PosMax) : pos_wide[PosW-1:0];
  assign delta    = $signed({{(DeltaW-TargetW){1'b0}}, item_q.target_q4})
                  - $signed({2'b00, pos_calc, 4'b0000});
  assign mag      = delta[DeltaW-1] ? DeltaW'(-delta) : DeltaW'(delta);
  assign drive    = mag > DeltaW'(dband_q);

  always_comb begin
    last_pos_d = last_pos_q;
    pos_d      = pos_q;
    duty_d    = '0;
    toward_d  = 1'b1;
    enable_d  = 1'b1;
    arrived_d = 1'b0;
    unique case (item_q.op)
      OpBeginHome: begin
        duty_d = home_duty_q;
      end
      OpHomeHit: begin
        enable_d = 1'b0;
        pos_d    = '0;
      end
      default: begin
        pos_d      = pos_calc;
        last_pos_d = !delta[DeltaW-1] && (delta != '0);
        if (drive) begin
          duty_d   = last_pos_d ? up_duty_q : down_duty_q;
          toward_d = !last_pos_d;
        end else begin
          duty_d    = hold_duty_q;
          toward_d  = 1'b0;
          arrived_d = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rev_q       <= '0;
      armed_q     <= 1'b1;
      last_pos_q  <= 1'b0;
      pos_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) begin
        rev_q      <= rev_d;
        armed_q    <= armed_d;
        last_pos_q <= last_pos_d;
        pos_q      <= pos_d;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      duty_o        <= duty_d;
      toward_home_o <= toward_d;
      enable_o      <= enable_d;
      position_cm_o <= pos_d;
      arrived_o     <= arrived_d;
    end
  end

  a_arrived_holds_up : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && arrived_o |-> !toward_home_o && enable_o)
    else $error("arrived item not driving hold upward");

  a_disabled_at_home : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !enable_o |-> position_cm_o == '0 && duty_o == '0)
    else $error("disabled item with nonzero position or duty");

  a_state_only_on_advance : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(rev_q) && $stable(pos_q) && $stable(armed_q))
    else $error("axis state changed without an item");

  a_stall_holds_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(item_q))
    else $error("input stage lost a stalled item");

endmodule

`default_nettype wire

@@ test/axis_bang_bang_positioner_tb.sv @@
// ----------------------------------------------------------------------------
// axis_bang_bang_positioner_tb
// Self-checking bench for the bang-bang axis positioner: a directed table
// covers homing, drive, hold, the deadband edges and every wrap-tracking
// branch (including the revolution count wrapping below zero), then random
// move sequences with encoder trajectories run under several duty and
// deadband settings. Each result is compared with an in-bench prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module axis_bang_bang_positioner_tb;
  import axbbp_pkg::*;

  localparam int unsigned CntPerCm   = 3855;
  localparam int unsigned CmPerRev   = 17;
  localparam int unsigned WrapHi     = 61680;
  localparam int unsigned CmLimit    = 8191;
  localparam int          NumDir     = 22;
  localparam int          NumPhases  = 6;
  localparam int          PerPhase   = 192;
  localparam int          StallLimit = 1000;
  localparam logic [CfgIdxW-1:0] CfgSpare = 3'd7;

  typedef struct packed {
    logic [DutyW-1:0] duty;
    logic             toward_home;
    logic             enable;
    logic [PosW-1:0]  position_cm;
    logic             arrived;
  } drive_cmd_t;

  typedef struct packed {
    op_e                op;
    logic [TargetW-1:0] target;
    logic [CountW-1:0]  count;
    logic               typed;
    drive_cmd_t         cmd;
  } dir_row_t;

  localparam drive_cmd_t NoCmd = '0;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  cfg_we_i        = 1'b0;
  logic [CfgIdxW-1:0]    cfg_idx_i       = '0;
  logic [DutyW-1:0]      cfg_data_i      = '0;
  logic                  in_valid_i      = 1'b0;
  logic                  in_ready_o;
  op_e                   op_i            = OpBeginHome;
  logic [TargetW-1:0]    target_q4_i     = '0;
  logic [CountW-1:0]     encoder_count_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i     = 1'b0;
  logic [DutyW-1:0]      duty_o;
  logic                  toward_home_o;
  logic                  enable_o;
  logic [PosW-1:0]       position_cm_o;
  logic                  arrived_o;

  axis_bang_bang_positioner dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .op_i,
    .target_q4_i,
    .encoder_count_i,
    .out_valid_o,
    .out_ready_i,
    .duty_o,
    .toward_home_o,
    .enable_o,
    .position_cm_o,
    .arrived_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Axis state and registers as the block should hold them
  logic [DutyW-1:0]  up_duty_q, down_duty_q, hold_duty_q, home_duty_q;
  logic [DbandW-1:0] dband_q;
  logic [RevW-1:0]   revs_q;
  logic              armed_q, went_up_q;
  logic [PosW-1:0]   pos_q;

  drive_cmd_t drive_cmds_q[$];
  drive_cmd_t last_cmd;
  op_e        plan_q[$];
  logic [CountW-1:0]  traj_count;
  logic [TargetW-1:0] traj_target;

  int items_sent, cmds_checked, cmd_mismatches, settings_run, rev_wraps, max_cm;
  int send_idle_pct, sink_idle_pct, sink_stall_left, quiet_cycles;

  function automatic logic [PosW-1:0] count_to_cm(logic [CountW-1:0] cnt);
    int unsigned cm;
    cm = cnt / CntPerCm + revs_q * CmPerRev;
    return (cm > CmLimit) ? PosW'(CmLimit) : PosW'(cm);
  endfunction

  function automatic drive_cmd_t next_drive_cmd(item_t it);
    drive_cmd_t cmd;
    logic       hi, lo;
    int         err, mag;
    cmd = '0;
    case (it.op)
      OpBeginHome: begin
        cmd = '{home_duty_q, 1'b1, 1'b1, pos_q, 1'b0};
      end
      OpHomeHit: begin
        pos_q  = '0;
        revs_q = '0;
        cmd    = '{'0, 1'b1, 1'b0, '0, 1'b0};
      end
      default: begin
        if (it.op == OpSample) begin
          hi = it.encoder_count > WrapHi;
          lo = it.encoder_count < CntPerCm;
          if (hi && went_up_q && armed_q) begin
            armed_q = 1'b0;
          end else if (lo && went_up_q && !armed_q) begin
            armed_q = 1'b1;
            if (revs_q == '1) rev_wraps++;
            revs_q = revs_q + RevW'(1);
          end else if (lo && !went_up_q) begin
            armed_q = 1'b0;
          end else if (hi && !went_up_q && !armed_q) begin
            armed_q = 1'b1;
            if (revs_q == '0) rev_wraps++;
            revs_q = revs_q - RevW'(1);
          end
        end
        pos_q = count_to_cm(it.encoder_count);
        if (int'(pos_q) > max_cm) max_cm = int'(pos_q);
        err = int'(it.target_q4) - 16 * int'(pos_q);
        mag = (err < 0) ? -err : err;
        went_up_q = err > 0;
        if (mag > int'(dband_q)) begin
          cmd = '{(err > 0) ? up_duty_q : down_duty_q, !(err > 0), 1'b1, pos_q, 1'b0};
        end else begin
          cmd = '{hold_duty_q, 1'b0, 1'b1, pos_q, 1'b1};
        end
      end
    endcase
    return cmd;
  endfunction

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [DutyW-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CfgUpDuty:   up_duty_q   = val;
      CfgDownDuty: down_duty_q = val;
      CfgHoldDuty: hold_duty_q = val;
      CfgHomeDuty: home_duty_q = val;
      CfgDband:    dband_q     = val[DbandW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_all(logic [DutyW-1:0] up, logic [DutyW-1:0] down,
                           logic [DutyW-1:0] hold, logic [DutyW-1:0] home,
                           logic [DutyW-1:0] band);
    cfg_write(CfgUpDuty, up);
    cfg_write(CfgDownDuty, down);
    cfg_write(CfgHoldDuty, hold);
    cfg_write(CfgHomeDuty, home);
    cfg_write(CfgDband, band);
  endtask

  task automatic send_item(item_t it, logic typed, drive_cmd_t typed_cmd);
    drive_cmd_t cmd;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= it.op;
    target_q4_i     <= it.target_q4;
    encoder_count_i <= it.encoder_count;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    cmd      = next_drive_cmd(it);
    last_cmd = cmd;
    drive_cmds_q.push_back(typed ? typed_cmd : cmd);
    items_sent++;
  endtask

  // Mostly well-formed moves (optional homing, start, encoder trajectory), some noise
  function automatic item_t make_item();
    item_t it;
    int    step;
    if ($urandom_range(99) < 15) begin
      it.op            = op_e'($urandom_range(3));
      it.target_q4     = TargetW'($urandom);
      it.encoder_count = CountW'($urandom);
      return it;
    end
    if (plan_q.size() == 0) begin
      if ($urandom_range(3) == 0) begin
        plan_q.push_back(OpBeginHome);
        plan_q.push_back(OpHomeHit);
      end
      plan_q.push_back(OpStartMove);
      repeat ($urandom_range(40, 5)) plan_q.push_back(OpSample);
      traj_target = TargetW'($urandom);
    end
    it.op = plan_q.pop_front();
    if (it.op == OpSample) begin
      step = $urandom_range(4000);
      if (last_cmd.arrived)
        traj_count = traj_count + CountW'($urandom_range(300)) - CountW'(150);
      else if (last_cmd.toward_home)
        traj_count = traj_count - CountW'(step);
      else
        traj_count = traj_count + CountW'(step);
    end
    it.target_q4     = traj_target;
    it.encoder_count = traj_count;
    return it;
  endfunction

  always @(posedge clk_i) begin : sink
    drive_cmd_t want, got;
    if (out_valid_o && out_ready_i) begin
      got = '{duty_o, toward_home_o, enable_o, position_cm_o, arrived_o};
      if (drive_cmds_q.size() == 0) begin
        cmd_mismatches++;
        if (cmd_mismatches <= 10)
          $display("unexpected result: duty %0d dir %0b en %0b pos %0d arr %0b",
                   got.duty, got.toward_home, got.enable, got.position_cm, got.arrived);
      end else begin
        want = drive_cmds_q.pop_front();
        cmds_checked++;
        if (got !== want) begin
          cmd_mismatches++;
          if (cmd_mismatches <= 10)
            $display("result %0d: expected duty %0d dir %0b en %0b pos %0d arr %0b, got duty %0d dir %0b en %0b pos %0d arr %0b",
                     cmds_checked, want.duty, want.toward_home, want.enable,
                     want.position_cm, want.arrived, got.duty, got.toward_home,
                     got.enable, got.position_cm, got.arrived);
        end
      end
    end
    if (sink_stall_left != 0) begin
      out_ready_i     <= 1'b0;
      sink_stall_left <= sink_stall_left - 1;
    end else if (sink_idle_pct != 0 && $urandom_range(99) < sink_idle_pct) begin
      out_ready_i     <= 1'b0;
      sink_stall_left <= $urandom_range(14);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  dir_row_t dir_rows [NumDir] = '{
    '{OpBeginHome, 10'd0,    16'd0,     1'b1, '{10'd115, 1'b1, 1'b1, 13'd0,    1'b0}},
    '{OpHomeHit,   10'd0,    16'd0,     1'b1, '{10'd0,   1'b1, 1'b0, 13'd0,    1'b0}},
    '{OpStartMove, 10'd0,    16'd0,     1'b1, '{10'd200, 1'b0, 1'b1, 13'd0,    1'b1}},
    '{OpStartMove, 10'd1023, 16'd65535, 1'b1, '{10'd450, 1'b0, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd1023, 16'd65535, 1'b1, '{10'd450, 1'b0, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd1023, 16'd0,     1'b1, '{10'd450, 1'b0, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd0,    16'd0,     1'b1, '{10'd100, 1'b1, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd0,    16'd0,     1'b1, '{10'd100, 1'b1, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd0,    16'd65535, 1'b1, '{10'd100, 1'b1, 1'b1, 13'd17,   1'b0}},
    '{OpSample,    10'd0,    16'd0,     1'b1, '{10'd200, 1'b0, 1'b1, 13'd0,    1'b1}},
    '{OpSample,    10'd0,    16'd65535, 1'b1, '{10'd100, 1'b1, 1'b1, 13'd4352, 1'b0}},
    '{OpBeginHome, 10'd1023, 16'd65535, 1'b1, '{10'd115, 1'b1, 1'b1, 13'd4352, 1'b0}},
    '{OpHomeHit,   10'd1023, 16'd65535, 1'b1, '{10'd0,   1'b1, 1'b0, 13'd0,    1'b0}},
    '{OpStartMove, 10'd24,   16'd0,     1'b1, '{10'd200, 1'b0, 1'b1, 13'd0,    1'b1}},
    '{OpStartMove, 10'd25,   16'd0,     1'b1, '{10'd450, 1'b0, 1'b1, 13'd0,    1'b0}},
    '{OpStartMove, 10'd8,    16'd7710,  1'b1, '{10'd200, 1'b0, 1'b1, 13'd2,    1'b1}},
    '{OpStartMove, 10'd7,    16'd7710,  1'b1, '{10'd100, 1'b1, 1'b1, 13'd2,    1'b0}},
    '{OpStartMove, 10'd1023, 16'd3854,  1'b0, NoCmd},
    '{OpSample,    10'd1023, 16'd61680, 1'b0, NoCmd},
    '{OpSample,    10'd1023, 16'd61681, 1'b0, NoCmd},
    '{OpSample,    10'd1023, 16'd3855,  1'b0, NoCmd},
    '{OpSample,    10'd1023, 16'd3854,  1'b0, NoCmd}
  };

  initial begin
    item_t it;
    up_duty_q       = 10'd450;
    down_duty_q     = 10'd100;
    hold_duty_q     = 10'd200;
    home_duty_q     = 10'd115;
    dband_q         = 8'd24;
    revs_q          = '0;
    armed_q         = 1'b1;
    went_up_q       = 1'b0;
    pos_q           = '0;
    last_cmd        = '0;
    traj_count      = '0;
    traj_target     = '0;
    items_sent      = 0;
    cmds_checked    = 0;
    cmd_mismatches  = 0;
    settings_run    = 1;
    rev_wraps       = 0;
    max_cm          = 0;
    sink_stall_left = 0;
    quiet_cycles    = 0;
    send_idle_pct   = 12;
    sink_idle_pct   = 12;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      it = '{dir_rows[i].op, dir_rows[i].target, dir_rows[i].count};
      send_item(it, dir_rows[i].typed, dir_rows[i].cmd);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      // hold input until the block has drained, then retune
      in_valid_i <= 1'b0;
      while (drive_cmds_q.size() != 0) @(posedge clk_i);
      repeat (4) @(posedge clk_i);
      case (ph)
        0: write_all('1, '1, '1, '1, '1);
        1: write_all('0, '0, '0, '0, '0);
        2: begin
          write_all(DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                    DutyW'($urandom), DutyW'($urandom));
          cfg_write(CfgSpare, DutyW'($urandom));
        end
        3: write_all(10'd450, 10'd100, 10'd200, 10'd115, 10'd24);
        default: write_all(DutyW'($urandom), DutyW'($urandom), DutyW'($urandom),
                           DutyW'($urandom), DutyW'($urandom_range(40)));
      endcase
      cfg_we_i <= 1'b0;
      settings_run++;
      for (int n = 0; n < PerPhase; n++) begin
        if (ph == NumPhases - 1) begin
          send_idle_pct = 0;
          sink_idle_pct = 0;
        end else if (n % 64 == 0) begin
          send_idle_pct = 12 * $urandom_range(2);
          sink_idle_pct = 12 * $urandom_range(2);
        end
        send_item(make_item(), 1'b0, NoCmd);
      end
    end

    in_valid_i <= 1'b0;
    while (drive_cmds_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Ran %0d items (%0d from the directed table) over %0d register settings, %0d results checked.",
             items_sent, NumDir, settings_run, cmds_checked);
    $display("Position reached %0d cm; revolution count wrapped %0d times.",
             max_cm, rev_wraps);
    if (cmd_mismatches == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
